// File: hdl/tsd_pkg.sv
// Package for the TLV stream decoder: number marks, parse phase codes, result kinds,
// field widths and the mark-to-byte-count helper. No dependencies.
package tsd_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int NUM_W  = 64;
  localparam int CNT_W  = 4;
  localparam int PH_W   = 3;
  localparam int DATA_W = NUM_W + NUM_W + BYTE_W;  // 136 bits, 17 whole bytes

  // Marks that announce an extended number
  localparam logic [BYTE_W-1:0] MARK_TWO   = 8'hfd;
  localparam logic [BYTE_W-1:0] MARK_FOUR  = 8'hfe;
  localparam logic [BYTE_W-1:0] MARK_EIGHT = 8'hff;

  // Parse phase codes
  localparam logic [PH_W-1:0] PH_TYPE_MARK  = 3'd0;
  localparam logic [PH_W-1:0] PH_TYPE_BYTES = 3'd1;
  localparam logic [PH_W-1:0] PH_LEN_MARK   = 3'd2;
  localparam logic [PH_W-1:0] PH_LEN_BYTES  = 3'd3;
  localparam logic [PH_W-1:0] PH_VALUE      = 3'd4;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  // Extension bytes after a mark; zero when the mark is the number itself
  function automatic logic [CNT_W-1:0] ext_count(input logic [BYTE_W-1:0] mark);
    logic [CNT_W-1:0] n;
    n = 4'd0;
    if (mark == MARK_EIGHT) n = 4'd8;
    else if (mark == MARK_FOUR) n = 4'd4;
    else if (mark == MARK_TWO) n = 4'd2;
    return n;
  endfunction

endpackage

// File: hdl/tlv_stream_decoder_unit.sv
// TLV stream decoder top level: parse state registers, next-state logic
// and the result register. Depends on tsd_pkg.
//
// Usage:
//   Slave channel (s_*) takes one raw stream byte per beat in s_tdata.
//   Master channel (m_*) gives at most one result per input byte:
//     m_tuser = kind (0 header, 1 value byte), m_tlast = last result of
//     the element, m_tdata = {value_byte, value_length, type_number}.
//   Bytes that only build a type or length number give no result.
//   A header beat carries the decoded type and length; each value beat
//   repeats them with the value byte. A zero-length element's header beat
//   has m_tlast set.
//   Latency: a result appears on m_* the cycle after its byte is taken.
//   Throughput: one byte per cycle while the receiver keeps up; the parse state
//   update (a 64-bit count-down and compare) is combinational, so bytes go back to back.
//   s_tready is high while the result register is empty or being drained;
//   when the receiver holds m_tready low with a result waiting, the input
//   stalls until that beat is taken.
//   Reset (rst, synchronous, active high) empties the result register and
//   returns the parser to expecting a type mark, with all counts cleared.
module tlv_stream_decoder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [tsd_pkg::BYTE_W-1:0] s_tdata,  // [7:0] stream_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [63:0] type_number, [127:64] value_length, [135:128] value_byte
  output logic [tsd_pkg::DATA_W-1:0] m_tdata,
  output logic                      m_tuser,   // [0] kind
  output logic                      m_tlast
);
  import tsd_pkg::*;

  // Parse state
  logic [PH_W-1:0]   phase, phase_next;
  logic [CNT_W-1:0]  num_left, num_left_next;
  logic [NUM_W-1:0]  type_acc, type_acc_next;
  logic [NUM_W-1:0]  len_acc, len_acc_next;
  logic [NUM_W-1:0]  remaining, remaining_next;

  // Result produced by the current byte
  logic              emit;
  logic              emit_kind;
  logic              emit_last;
  logic [BYTE_W-1:0] emit_byte;

  // Result register payload
  logic [NUM_W-1:0]  out_type, out_len;
  logic [BYTE_W-1:0] out_byte;
  logic              out_kind, out_last;

  logic              in_beat;
  logic [CNT_W-1:0]  mark_n;
  logic [CNT_W-1:0]  num_left_dec;
  logic [NUM_W-1:0]  len_shift;

  assign s_tready     = !m_tvalid || m_tready;
  assign in_beat      = s_tvalid && s_tready;
  assign mark_n       = ext_count(s_tdata);
  assign num_left_dec = num_left - 4'd1;
  assign len_shift    = {len_acc[NUM_W-BYTE_W-1:0], s_tdata};

  // Next-state logic for one stream byte
  always_comb begin
    phase_next     = phase;
    num_left_next  = num_left;
    type_acc_next  = type_acc;
    len_acc_next   = len_acc;
    remaining_next = remaining;
    emit           = 1'b0;
    emit_kind      = KIND_HEADER;
    emit_last      = 1'b0;
    emit_byte      = '0;
    unique case (phase)
      PH_TYPE_BYTES: begin
        type_acc_next = {type_acc[NUM_W-BYTE_W-1:0], s_tdata};
        num_left_next = num_left_dec;
        if (num_left_dec == '0) phase_next = PH_LEN_MARK;
      end
      PH_LEN_MARK: begin
        if (mark_n == '0) begin
          len_acc_next = {{(NUM_W-BYTE_W){1'b0}}, s_tdata};
          emit         = 1'b1;
          if (s_tdata == '0) begin
            emit_last  = 1'b1;
            phase_next = PH_TYPE_MARK;
          end else begin
            remaining_next = {{(NUM_W-BYTE_W){1'b0}}, s_tdata};
            phase_next     = PH_VALUE;
          end
        end else begin
          len_acc_next  = '0;
          num_left_next = mark_n;
          phase_next    = PH_LEN_BYTES;
        end
      end
      PH_LEN_BYTES: begin
        len_acc_next  = len_shift;
        num_left_next = num_left_dec;
        if (num_left_dec == '0) begin
          emit = 1'b1;
          if (len_shift == '0) begin
            emit_last  = 1'b1;
            phase_next = PH_TYPE_MARK;
          end else begin
            remaining_next = len_shift;
            phase_next     = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        remaining_next = remaining - 64'd1;
        emit           = 1'b1;
        emit_kind      = KIND_VALUE;
        emit_byte      = s_tdata;
        if (remaining == 64'd1) begin
          emit_last  = 1'b1;
          phase_next = PH_TYPE_MARK;
        end
      end
      default: begin
        // type mark expected; unused codes fall here too
        len_acc_next   = '0;
        remaining_next = '0;
        if (mark_n == '0) begin
          type_acc_next = {{(NUM_W-BYTE_W){1'b0}}, s_tdata};
          num_left_next = '0;
          phase_next    = PH_LEN_MARK;
        end else begin
          type_acc_next = '0;
          num_left_next = mark_n;
          phase_next    = PH_TYPE_BYTES;
        end
      end
    endcase
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TYPE_MARK;
      num_left  <= '0;
      type_acc  <= '0;
      len_acc   <= '0;
      remaining <= '0;
    end else if (in_beat) begin
      phase     <= phase_next;
      num_left  <= num_left_next;
      type_acc  <= type_acc_next;
      len_acc   <= len_acc_next;
      remaining <= remaining_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (in_beat && emit) begin
      out_type <= type_acc_next;
      out_len  <= len_acc_next;
      out_byte <= emit_byte;
      out_kind <= emit_kind;
      out_last <= emit_last;
    end
  end

  assign m_tdata = {out_byte, out_len, out_type};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// File: tb/tlv_stream_decoder_unit_tb.sv
// Self-checking testbench for tlv_stream_decoder_unit: feeds TLV byte streams,
// predicts header and value beats in-line and checks every output beat.
// Depends on tsd_pkg and the tlv_stream_decoder_unit RTL.
module tlv_stream_decoder_unit_tb;
  import tsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One output beat, split into its fields
  typedef struct packed {
    logic              kind;
    logic [NUM_W-1:0]  type_number;
    logic [NUM_W-1:0]  value_length;
    logic [BYTE_W-1:0] value_byte;
    logic              last;
  } tlv_beat_t;

  // Encoding forms of a variable-size number
  typedef enum int {FORM_SHORT, FORM_TWO, FORM_FOUR, FORM_EIGHT} num_form_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  // Stream bytes waiting to go out, and beats the decoder still owes us
  logic [BYTE_W-1:0]   stream_q[$];
  tlv_beat_t           beats_due_q[$];
  int                  bytes_queued = 0;
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  // Shadow parse state
  logic [PH_W-1:0]     sh_phase = PH_TYPE_MARK;
  logic [CNT_W-1:0]    sh_num_left = '0;
  logic [NUM_W-1:0]    sh_type = '0;
  logic [NUM_W-1:0]    sh_len = '0;
  logic [NUM_W-1:0]    sh_value_left = '0;

  tlv_stream_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Length number done: queue the header beat, then go to value or next type
  task automatic close_header();
    tlv_beat_t hdr;
    hdr = '{kind: KIND_HEADER, type_number: sh_type, value_length: sh_len,
            value_byte: '0, last: (sh_len == '0)};
    beats_due_q.push_back(hdr);
    if (sh_len == '0) begin
      sh_phase = PH_TYPE_MARK;
    end else begin
      sh_value_left = sh_len;
      sh_phase = PH_VALUE;
    end
  endtask

  // Advance the shadow parser by one accepted stream byte
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] ext;
    tlv_beat_t        vb;
    case (b)
      MARK_EIGHT: ext = 4'd8;
      MARK_FOUR:  ext = 4'd4;
      MARK_TWO:   ext = 4'd2;
      default:    ext = 4'd0;
    endcase
    case (sh_phase)
      PH_TYPE_BYTES: begin
        sh_type = {sh_type[NUM_W-BYTE_W-1:0], b};
        sh_num_left = sh_num_left - 1'b1;
        if (sh_num_left == '0) sh_phase = PH_LEN_MARK;
      end
      PH_LEN_MARK: begin
        if (ext == '0) begin
          sh_len = NUM_W'(b);
          close_header();
        end else begin
          sh_len = '0;
          sh_num_left = ext;
          sh_phase = PH_LEN_BYTES;
        end
      end
      PH_LEN_BYTES: begin
        sh_len = {sh_len[NUM_W-BYTE_W-1:0], b};
        sh_num_left = sh_num_left - 1'b1;
        if (sh_num_left == '0) close_header();
      end
      PH_VALUE: begin
        sh_value_left = sh_value_left - 1'b1;
        vb = '{kind: KIND_VALUE, type_number: sh_type, value_length: sh_len,
               value_byte: b, last: (sh_value_left == '0)};
        beats_due_q.push_back(vb);
        if (sh_value_left == '0) sh_phase = PH_TYPE_MARK;
      end
      default: begin
        // type mark; unused phase codes land here too
        sh_len = '0;
        sh_value_left = '0;
        if (ext == '0) begin
          sh_type = NUM_W'(b);
          sh_num_left = '0;
          sh_phase = PH_LEN_MARK;
        end else begin
          sh_type = '0;
          sh_num_left = ext;
          sh_phase = PH_TYPE_BYTES;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [NUM_W-1:0] want,
                             input logic [NUM_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Stimulus builders
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    stream_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_number(input logic [NUM_W-1:0] v, input num_form_t form);
    int nb;
    case (form)
      FORM_TWO:   begin push_byte(MARK_TWO);   nb = 2; end
      FORM_FOUR:  begin push_byte(MARK_FOUR);  nb = 4; end
      FORM_EIGHT: begin push_byte(MARK_EIGHT); nb = 8; end
      default:    nb = 0;
    endcase
    if (nb == 0) push_byte(v[BYTE_W-1:0]);
    for (int i = nb - 1; i >= 0; i--) push_byte(v[i*8 +: 8]);
  endtask

  // Header plus nvalue value bytes (nvalue is the length except at the very end)
  task automatic push_element(input logic [NUM_W-1:0] t, input num_form_t tform,
                              input logic [NUM_W-1:0] len, input num_form_t lform,
                              input int nvalue);
    push_number(t, tform);
    push_number(len, lform);
    repeat (nvalue) push_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic push_random_element();
    num_form_t        tform, lform;
    logic [NUM_W-1:0] t, len;
    tform = num_form_t'($urandom_range(0, 3));
    case (tform)
      FORM_SHORT: t = NUM_W'($urandom_range(0, 252));
      FORM_TWO:   t = NUM_W'($urandom_range(0, 65535));
      FORM_FOUR:  t = NUM_W'($urandom);
      default:    t = {$urandom, $urandom};
    endcase
    // all-ones type only fits the eight-byte form
    if ($urandom_range(0, 15) == 0) begin
      t = '1;
      tform = FORM_EIGHT;
    end
    len = ($urandom_range(0, 9) < 2) ? '0 : NUM_W'($urandom_range(1, 12));
    lform = ($urandom_range(0, 9) < 6) ? FORM_SHORT : num_form_t'($urandom_range(1, 3));
    push_element(t, tform, len, lform, int'(len));
  endtask

  // Sender holds off until the decoder has delivered every owed beat
  task automatic wait_drained();
    while (stream_q.size() != 0 || s_tvalid || beats_due_q.size() != 0) @(posedge clk);
  endtask

  // Driver: present the next byte once the current beat is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= stream_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : monitor_blk
    tlv_beat_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        got = '{kind: m_tuser, type_number: m_tdata[63:0], value_length: m_tdata[127:64],
                value_byte: m_tdata[135:128], last: m_tlast};
        if (beats_due_q.size() == 0) begin
          $error("unexpected output beat: kind %0h type %0h length %0h",
                 got.kind, got.type_number, got.value_length);
          mismatch_count++;
        end else begin
          want = beats_due_q.pop_front();
          check_field("kind", NUM_W'(want.kind), NUM_W'(got.kind));
          check_field("type_number", want.type_number, got.type_number);
          check_field("value_length", want.value_length, got.value_length);
          check_field("value_byte", NUM_W'(want.value_byte), NUM_W'(got.value_byte));
          check_field("last", NUM_W'(want.last), NUM_W'(got.last));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus sequence
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int target;
    idle_tab  = '{0, 87, 0, 9};
    stall_tab = '{0, 0, 87, 9};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      if (p == 0) begin
        // zero-length element with the smallest type
        push_element('0, FORM_SHORT, '0, FORM_SHORT, 0);
        // largest short-form type, one value byte
        push_byte(8'hfc);
        push_byte(8'h01);
        push_byte(8'hff);
        // two-byte type and length, value bytes 00 and 80
        push_element(64'h1234, FORM_TWO, 64'd2, FORM_TWO, 0);
        push_byte(8'h00);
        push_byte(8'h80);
        // four-byte all-ones type, zero length in long form
        push_element(64'hffff_ffff, FORM_FOUR, '0, FORM_FOUR, 0);
      end
      target = bytes_queued + 120;
      while (bytes_queued < target) push_random_element();
      wait_drained();
    end

    // Largest type and length: header, then three value bytes of that element
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_element('1, FORM_EIGHT, '1, FORM_EIGHT, 3);
    wait_drained();
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && beats_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
